// ===== rtl/core/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types, codes and reset values for the door controller.
// ----------------------------------------------------------------------------
package dcf_pkg;

    // debounce depth: consecutive equal samples needed for a stable reading
    localparam int unsigned DEBOUNCE_SAMPLES = 4;

    localparam int unsigned TIME_W  = 17;
    localparam int unsigned LIMIT_W = 16;

    // time-in-state counter stops here
    localparam logic [TIME_W-1:0] TIME_SAT = TIME_W'(65536);

    typedef logic [DEBOUNCE_SAMPLES-1:0] t_hist;
    typedef logic [TIME_W-1:0]           t_time;
    typedef logic [LIMIT_W-1:0]          t_limit;

    // item kinds
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_POLL  = 2'd1,
        FUNC_OPEN  = 2'd2,
        FUNC_CLOSE = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_OPEN_TIMEOUT       = 3'd0,
        CFG_CLOSE_TIMEOUT      = 3'd1,
        CFG_OPEN_START_TIMEOUT = 3'd2,
        CFG_PULSE_LENGTH       = 3'd3,
        CFG_SENSOR_ACTIVE_HIGH = 3'd4,
        CFG_BUTTON_ACTIVE_HIGH = 3'd5,
        CFG_BUTTON_PRESENT     = 3'd6,
        CFG_UNUSED             = 3'd7
    } t_cfg_index;

    // reset values of the configuration registers
    localparam t_limit RST_OPEN_TIMEOUT       = 16'd10000;
    localparam t_limit RST_CLOSE_TIMEOUT      = 16'd10000;
    localparam t_limit RST_OPEN_START_TIMEOUT = 16'd4000;
    localparam t_limit RST_PULSE_LENGTH       = 16'd300;

    // door states, one-hot
    typedef enum logic [6:0] {
        ST_INIT        = 7'b000_0001,
        ST_CLOSED      = 7'b000_0010,
        ST_OPEN        = 7'b000_0100,
        ST_OPEN_SENSED = 7'b000_1000,
        ST_OPEN_START  = 7'b001_0000,
        ST_OPENING     = 7'b010_0000,
        ST_CLOSING     = 7'b100_0000
    } t_door_state;

    // externally visible door state codes
    localparam logic [2:0] CODE_INIT        = 3'd0;
    localparam logic [2:0] CODE_CLOSED      = 3'd1;
    localparam logic [2:0] CODE_OPEN        = 3'd2;
    localparam logic [2:0] CODE_OPEN_SENSED = 3'd3;
    localparam logic [2:0] CODE_OPEN_START  = 3'd4;
    localparam logic [2:0] CODE_OPENING     = 3'd5;
    localparam logic [2:0] CODE_CLOSING     = 3'd6;

    // one-hot state to output code
    function automatic logic [2:0] state_code(input t_door_state s);
        logic [2:0] c;
        c = CODE_INIT;
        unique case (s)
            ST_INIT:        c = CODE_INIT;
            ST_CLOSED:      c = CODE_CLOSED;
            ST_OPEN:        c = CODE_OPEN;
            ST_OPEN_SENSED: c = CODE_OPEN_SENSED;
            ST_OPEN_START:  c = CODE_OPEN_START;
            ST_OPENING:     c = CODE_OPENING;
            ST_CLOSING:     c = CODE_CLOSING;
            default:        c = CODE_INIT;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/door_controller_fsm.sv =====
// ----------------------------------------------------------------------------
// door_controller_fsm
// Garage door controller: sensor debounce, door state tracking, timeouts and
// push-button pulse generation. Takes one transaction per clock while the
// input is not stalled; each input transaction is captured in the input
// register, processed from there and its result lands in an output
// register, so one transaction per clock is sustained as long as the
// output side keeps up. Back-pressure on the output holds the input
// register and then stalls the input. Configuration writes are always taken
// (ready is tied high) and must be made while no transaction is in flight.
// ----------------------------------------------------------------------------
module door_controller_fsm
    import dcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic        i_closed_raw,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_door_state,
    output logic        o_state_changed,
    output logic        o_command_accepted,
    output logic        o_command_rejected,
    output logic        o_timeout_warning,
    output logic        o_button_drive,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    t_limit r_open_timeout, r_close_timeout, r_open_start_timeout, r_pulse_length;
    logic   r_sensor_ah, r_button_ah, r_button_present;

    // input register
    logic  r_in_valid;
    t_func r_func;
    logic  r_raw;

    // door state
    t_door_state r_state, n_state;
    t_hist       r_hist, n_hist;
    t_time       r_time, n_time;
    t_limit      r_pulse, n_pulse;

    // result flags of the current item
    logic n_changed, n_accepted, n_rejected, n_warn, n_drive;
    logic sample, is_closed, is_open;

    // pipeline advance: output register free or being emptied
    logic adv;
    logic do_item;

    assign adv        = !o_out_valid || !i_out_stall;
    assign do_item    = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign o_cfg_ready = 1'b1;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_timeout       <= RST_OPEN_TIMEOUT;
            r_close_timeout      <= RST_CLOSE_TIMEOUT;
            r_open_start_timeout <= RST_OPEN_START_TIMEOUT;
            r_pulse_length       <= RST_PULSE_LENGTH;
            r_sensor_ah          <= 1'b1;
            r_button_ah          <= 1'b1;
            r_button_present     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_OPEN_TIMEOUT:       r_open_timeout       <= i_cfg_data;
                CFG_CLOSE_TIMEOUT:      r_close_timeout      <= i_cfg_data;
                CFG_OPEN_START_TIMEOUT: r_open_start_timeout <= i_cfg_data;
                CFG_PULSE_LENGTH:       r_pulse_length       <= i_cfg_data;
                CFG_SENSOR_ACTIVE_HIGH: r_sensor_ah          <= i_cfg_data[0];
                CFG_BUTTON_ACTIVE_HIGH: r_button_ah          <= i_cfg_data[0];
                CFG_BUTTON_PRESENT:     r_button_present     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= t_func'(i_func);
            r_raw  <= i_closed_raw;
        end
    end

    // polarity-corrected sample and debounce decision
    always_comb begin
        sample    = r_raw ^ ~r_sensor_ah;
        n_hist    = t_hist'({r_hist, sample});
        is_closed = &n_hist;
        is_open   = ~|n_hist;
    end

    // item processing
    always_comb begin
        n_state    = r_state;
        n_time     = r_time;
        n_pulse    = r_pulse;
        n_changed  = 1'b0;
        n_accepted = 1'b0;
        n_rejected = 1'b0;
        n_warn     = 1'b0;
        unique case (r_func)
            FUNC_TICK: begin
                if (r_time != TIME_SAT) begin
                    n_time = r_time + t_time'(1);
                end
                if (r_pulse != '0) begin
                    n_pulse = r_pulse - t_limit'(1);
                end
            end
            FUNC_POLL: begin
                unique case (r_state)
                    ST_INIT: begin
                        if (is_closed) begin
                            n_state = ST_CLOSED;
                        end else if (is_open) begin
                            n_state = ST_OPEN;
                        end
                    end
                    ST_CLOSED: begin
                        if (is_open) begin
                            n_state = ST_OPEN_SENSED;
                        end
                    end
                    ST_OPEN: begin
                        if (is_closed) begin
                            n_state = ST_CLOSED;
                        end
                    end
                    ST_OPEN_START: begin
                        if (is_open) begin
                            n_state = ST_OPENING;
                        end else if (r_time > {1'b0, r_open_start_timeout}) begin
                            n_state = ST_CLOSED;
                            n_warn  = 1'b1;
                        end
                    end
                    ST_OPENING, ST_OPEN_SENSED: begin
                        if (is_closed) begin
                            n_state = ST_CLOSED;
                        end else if (r_time > {1'b0, r_open_timeout}) begin
                            n_state = ST_OPEN;
                        end
                    end
                    ST_CLOSING: begin
                        if (is_closed) begin
                            n_state = ST_CLOSED;
                        end else if (r_time > {1'b0, r_close_timeout}) begin
                            n_state = ST_OPEN;
                            n_warn  = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (n_state != r_state) begin
                    n_changed = 1'b1;
                    n_time    = '0;
                end
            end
            FUNC_OPEN, FUNC_CLOSE: begin
                if ((r_func == FUNC_OPEN && r_state == ST_CLOSED) ||
                    (r_func == FUNC_CLOSE && r_state == ST_OPEN)) begin
                    n_state    = (r_func == FUNC_OPEN) ? ST_OPEN_START : ST_CLOSING;
                    n_time     = '0;
                    n_changed  = 1'b1;
                    n_accepted = 1'b1;
                    if (r_button_present) begin
                        n_pulse = r_pulse_length;
                    end
                end else begin
                    n_rejected = 1'b1;
                end
            end
            default: ;
        endcase
        // button line level after the item
        if (!r_button_present) begin
            n_drive = 1'b0;
        end else if (n_pulse != '0) begin
            n_drive = r_button_ah;
        end else begin
            n_drive = ~r_button_ah;
        end
    end

    // door state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_hist  <= '0;
            r_time  <= '0;
            r_pulse <= '0;
        end else if (do_item) begin
            r_state <= n_state;
            r_time  <= n_time;
            r_pulse <= n_pulse;
            if (r_func == FUNC_POLL) begin
                r_hist <= n_hist;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_item) begin
            o_door_state       <= state_code(n_state);
            o_state_changed    <= n_changed;
            o_command_accepted <= n_accepted;
            o_command_rejected <= n_rejected;
            o_timeout_warning  <= n_warn;
            o_button_drive     <= n_drive;
        end
    end

    // checks on the processing logic
    a_acc_rej_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_command_accepted && o_command_rejected))
        else $error("command both accepted and rejected");

    a_acc_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command_accepted) |->
            (o_state_changed && (o_door_state == CODE_OPEN_START ||
                                 o_door_state == CODE_CLOSING)))
        else $error("accepted command did not enter open-start or closing");

    a_warn_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timeout_warning) |->
            (o_state_changed && (o_door_state == CODE_CLOSED ||
                                 o_door_state == CODE_OPEN)))
        else $error("timeout warning without fallback transition");

    a_time_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time <= TIME_SAT)
        else $error("time-in-state counter beyond saturation");

    a_change_clears_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_item && n_changed) |=> (r_time == '0))
        else $error("state change did not clear time-in-state");

endmodule
